// ----- design/mfst_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Max free space tree package
// Shared types, codes and constants of the free-space tournament tree.
// ----------------------------------------------------------------------------
package mfst_pkg;

  localparam int unsigned DefaultLeaves = 1024;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned ValW   = 16;
  localparam int unsigned FileW  = 15;
  localparam int unsigned PageW  = 32;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_CHANGE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOT_USE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_UP,
    S_DOWN,
    S_TAG,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [IdxW-1:0]  leaf_index;
    logic [ValW-1:0]  free_space;
    logic [ValW-1:0]  required_space;
    logic [FileW-1:0] file_number;
    logic [PageW-1:0] page_number;
  } mfst_in_t;

  typedef struct packed {
    logic [IdxW-1:0]  result_index;
    logic [ValW-1:0]  max_space;
    logic             found;
    logic [FileW-1:0] found_file;
    logic [PageW-1:0] found_page;
    logic [1:0]       status;
  } mfst_out_t;

  // Control flags of the sequencer's phases; busy stays high while any is set.
  typedef struct packed {
    logic up;    // climb: write the path node, pass the pair maximum upwards
    logic down;  // descend: compare the left child with the maximum
    logic clear; // reset sweep: zero the addressed entry
  } mfst_ctl_t;

endpackage
`default_nettype wire

// ----- design/max_free_space_tree.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Max free space tree
// Tournament tree of page free-space values with add, change and find.
// ----------------------------------------------------------------------------
// A transaction is taken on a rising edge with start high and busy low.
// busy rises on the next cycle and stays high until the cycle after the
// result strobe. Exactly one result follows each transaction: valid_o is high
// for one cycle with result_o; the receiver cannot stall it.
// Each level of the tree is one memory cell. An add or change climbs the
// levels, at each level a sibling read, then a fold. A find descends from
// the root, one level at a time, and then reads the tag. A refused add or
// change and an unknown command go straight to the result. The next
// transaction can be taken once busy is low again. The level memories have
// registered reads.
// After reset the block sweeps all level memories to zero, one entry per
// cycle in every level at once, with busy high.
// Unused leaves read as zero; tags of unwritten leaves are never reported.
// ----------------------------------------------------------------------------
module max_free_space_tree import mfst_pkg::*; #(
  parameter int unsigned LEAVES = DefaultLeaves
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  input  wire mfst_in_t  cmd_i,
  output logic           valid_o,
  output mfst_out_t      result_o
);

  localparam int unsigned Lv  = (LEAVES > 1) ? $clog2(LEAVES) : 1;
  localparam int unsigned Cap = 1 << Lv;
  localparam int unsigned LvW = $clog2(Lv + 1);
  localparam int unsigned CntW = Lv + 1;
  localparam int unsigned CmpW = (CntW > IdxW + 1) ? CntW : IdxW + 1;

  // Level l (0 = root, Lv = leaves) has 2**l entries.
  logic [Lv:0]      we;
  logic [Lv-1:0]    waddr [Lv+1];
  logic [ValW-1:0]  wdata [Lv+1];
  logic [Lv-1:0]    raddr [Lv+1];
  logic [ValW-1:0]  rdata [Lv+1];

  state_e           state_q, state_d;
  mfst_in_t         req_q;
  logic [CntW-1:0]  count_q, count_d;
  logic [Lv-1:0]    pos_q, pos_d;       // node position at current level
  logic [LvW-1:0]   lvl_q, lvl_d;
  logic [ValW-1:0]  acc_q, acc_d;       // value climbing / root maximum
  logic [ValW-1:0]  root_q, root_d;
  logic [CntW-1:0]  clr_q, clr_d;
  logic             first_q, first_d;
  mfst_out_t        res_q, res_d;
  logic             found_q, found_d;
  logic [Lv-1:0]    kidx_q, kidx_d;
  mfst_ctl_t        ctl;
  logic             accept;

  logic [FileW+PageW-1:0] tag_mem [Cap];
  logic [FileW+PageW-1:0] tag_rd;
  logic                   tag_we;

  for (genvar l = 0; l <= Lv; l++) begin : g_lvl
    localparam int unsigned D  = 1 << l;
    localparam int unsigned AW = (l == 0) ? 1 : l;
    logic [AW-1:0] wa, ra;
    assign wa = waddr[l][AW-1:0];
    assign ra = raddr[l][AW-1:0];
    mfst_level #(.Depth(D), .AW(AW)) u_level (
      .clk_i  (clk_i),
      .we_i   (we[l]),
      .waddr_i(wa),
      .wdata_i(wdata[l]),
      .raddr_i(ra),
      .rdata_o(rdata[l])
    );
  end

  // A transaction is taken only while idle and no result is on the ports.
  assign accept = start && (state_q == S_IDLE) && !valid_o;

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[count_q[Lv-1:0]] <= {req_q.file_number, req_q.page_number};
    end
    tag_rd <= tag_mem[kidx_q];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == CntW'(Cap - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_e'(cmd_i.cmd))
            CMD_ADD: state_d = (count_q >= CntW'(LEAVES)) ? S_DONE : S_UP;
            CMD_CHANGE: state_d = (CmpW'(cmd_i.leaf_index) >= CmpW'(count_q)) ?
                                  S_DONE : S_UP;
            CMD_FIND: state_d = S_DOWN;
            default: state_d = S_DONE;
          endcase
        end
      end
      S_UP:   if (lvl_q == '0 && !first_q) state_d = S_DONE;
      S_DOWN: if (lvl_q == LvW'(Lv) && !first_q) state_d = S_TAG;
      S_TAG:  if (!first_q) state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    count_d = count_q; pos_d = pos_q; lvl_d = lvl_q; acc_d = acc_q;
    root_d = root_q; clr_d = clr_q; first_d = first_q; res_d = res_q;
    found_d = found_q; kidx_d = kidx_q; tag_we = 1'b0;
    ctl = '0;
    for (int l = 0; l <= Lv; l++) begin
      we[l] = 1'b0; waddr[l] = pos_q >> (Lv - l); wdata[l] = acc_q;
      raddr[l] = (pos_q >> (Lv - l)) ^ Lv'(1);
    end
    unique case (state_q)
      S_CLEAR: begin
        ctl.clear = 1'b1;
        clr_d = clr_q + 1'b1;
        for (int l = 0; l <= Lv; l++) begin
          we[l] = 1'b1; waddr[l] = clr_q[Lv-1:0]; wdata[l] = '0;
        end
      end
      S_IDLE: begin
        first_d = 1'b1; lvl_d = LvW'(Lv);
        res_d = '0; found_d = 1'b0; kidx_d = '0;
        acc_d = accept ? cmd_i.free_space : acc_q;
        if (cmd_e'(cmd_i.cmd) == CMD_ADD) pos_d = count_q[Lv-1:0];
        else pos_d = Lv'(cmd_i.leaf_index);
        if (cmd_e'(cmd_i.cmd) == CMD_FIND) begin
          lvl_d = '0; pos_d = '0;
        end
      end
      S_UP: begin
        // The first step at a level issues the sibling read and writes this node;
        // the second folds the sibling into the value and moves up.
        ctl.up = 1'b1;
        if (first_q) begin
          for (int l = 0; l <= Lv; l++) we[l] = (LvW'(l) == lvl_q);
          first_d = (lvl_q == '0) ? 1'b0 : 1'b0;
          if (lvl_q == '0) root_d = acc_q;
        end else begin
          // The root has no sibling, so its value passes through unchanged.
          if (lvl_q != '0) acc_d = (rdata[lvl_q] > acc_q) ? rdata[lvl_q] : acc_q;
          lvl_d = lvl_q - 1'b1;
          first_d = 1'b1;
        end
      end
      S_DOWN: begin
        ctl.down = 1'b1;
        // read the left child of the path node one level down
        for (int l = 0; l <= Lv; l++) raddr[l] = (pos_q >> (Lv - l)) & ~Lv'(1);
        if (first_q) begin
          first_d = 1'b0;
        end else if (lvl_q != LvW'(Lv)) begin
          // rdata holds the left child at level lvl_q+1
          if (rdata[lvl_q + 1'b1] != root_q)
            pos_d = pos_q | (Lv'(1) << (Lv - 1 - lvl_q));
          lvl_d = lvl_q + 1'b1;
          first_d = 1'b1;
        end else begin
          first_d = 1'b1;
          kidx_d = pos_q;
          found_d = (count_q != '0) && (root_q >= req_q.required_space);
        end
      end
      S_TAG: first_d = 1'b0;
      S_DONE: begin
        res_d.max_space = root_q;
        res_d.status = ST_OK;
        unique case (cmd_e'(req_q.cmd))
          CMD_ADD: begin
            if (count_q >= CntW'(LEAVES)) res_d.status = ST_FULL;
            else begin
              res_d.result_index = IdxW'(count_q);
              res_d.max_space = acc_q;
              tag_we = 1'b1;
              count_d = count_q + 1'b1;
            end
          end
          CMD_CHANGE: begin
            if (CmpW'(req_q.leaf_index) >= CmpW'(count_q))
              res_d.status = ST_NOT_USE;
            else res_d.max_space = acc_q;
          end
          CMD_FIND: if (found_q) begin
            res_d.found = 1'b1; res_d.result_index = IdxW'(kidx_q);
            {res_d.found_file, res_d.found_page} = tag_rd;
          end
          default: ;
        endcase
        if (res_d.max_space != root_q) root_d = res_d.max_space;
        else if (res_d.status == ST_OK && cmd_e'(req_q.cmd) != CMD_FIND &&
                 cmd_e'(req_q.cmd) != CMD_NONE) root_d = acc_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; count_q <= '0; clr_q <= '0; root_q <= '0;
      valid_o <= 1'b0; lvl_q <= '0; first_q <= 1'b1; found_q <= 1'b0;
    end else begin
      state_q <= state_d; count_q <= count_d; clr_q <= clr_d; root_q <= root_d;
      valid_o <= (state_q == S_DONE); lvl_q <= lvl_d; first_q <= first_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) req_q <= cmd_i;
    pos_q <= pos_d; acc_q <= acc_d; res_q <= res_d; kidx_q <= kidx_d;
  end

  assign busy = (state_q != S_IDLE) || valid_o || (ctl != '0);
  assign result_o = res_q;

endmodule
`default_nettype wire

// ----- design/mfst_level.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tree level cell
// Holds the node maxima of one tree level in a memory. On a climb it is
// written with the value handed up from below and read at the sibling;
// on a descent it is read at the left child of the path node.
// ----------------------------------------------------------------------------
module mfst_level import mfst_pkg::*; #(
  parameter int unsigned Depth = 2,
  parameter int unsigned AW    = 1
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [AW-1:0]   waddr_i,
  input  wire logic [ValW-1:0] wdata_i,
  input  wire logic [AW-1:0]   raddr_i,
  output logic      [ValW-1:0] rdata_o
);

  logic [ValW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire
